// ===== src/slma_pkg.sv =====
// Package for the sorted list merge block: item payloads, opcodes and the
// command/status bundles between controller and datapath. No dependencies.
package slma_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned WeightW = 32;
  localparam int unsigned SumW    = 40;
  localparam int unsigned TotalW  = 7;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MERGE  = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [KeyW-1:0]    key;
    logic [WeightW-1:0] weight;
    logic [KeyW-1:0]    skip_key;
  } in_item_t;

  typedef struct packed {
    logic [KeyW-1:0]   out_key;
    logic [SumW-1:0]   out_weight;
    logic              last;
    logic              empty_res;
    logic [TotalW-1:0] total;
    logic              overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic take;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic a_more;
    logic b_more;
    logic take_stall;
    logic flush_stall;
  } sts_t;

endpackage

// ===== src/slma_ctrl.sv =====
// Controller for the sorted list merge block: sequences loads and the merge
// walk. Depends on slma_pkg for the opcode, command and status types.
module slma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  slma_pkg::sts_t    sts_i,
  output slma_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_TAKE  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (opcode_i)
            slma_pkg::OP_LOAD_A: cmd_o.load_a = 1'b1;
            slma_pkg::OP_LOAD_B: cmd_o.load_b = 1'b1;
            slma_pkg::OP_MERGE: begin
              cmd_o.start = 1'b1;
              state_d     = ST_READ;
            end
            default: ;
          endcase
        end
      end
      // the memory read for the current heads is registered in this state for ST_TAKE
      ST_READ: begin
        if (sts_i.a_more || sts_i.b_more) begin
          state_d = ST_TAKE;
        end else begin
          state_d = ST_FLUSH;
        end
      end
      ST_TAKE: begin
        cmd_o.take = 1'b1;
        if (!sts_i.take_stall) begin
          state_d = ST_READ;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (!sts_i.flush_stall) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/slma_dp.sv =====
// Datapath for the sorted list merge block: list memories, counts, head
// compare, pending result and output register. Depends on slma_pkg.
module slma_dp #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  slma_pkg::in_item_t  in_data_i,
  input  slma_pkg::cmd_t      cmd_i,
  output slma_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slma_pkg::out_item_t out_data_o
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned EW = slma_pkg::KeyW + slma_pkg::WeightW;
  localparam int unsigned KW = slma_pkg::KeyW;
  localparam int unsigned SW = slma_pkg::SumW;
  localparam int unsigned TW = slma_pkg::TotalW;

  logic [EW-1:0] mem_a [LIST_DEPTH];
  logic [EW-1:0] mem_b [LIST_DEPTH];
  logic [EW-1:0] rd_a_q, rd_b_q;

  logic [CW-1:0] cnt_a_q, cnt_b_q, ia_q, ib_q;
  logic          flag_q;
  logic [KW-1:0] skip_q;
  logic          have_q;
  logic [KW-1:0] pend_key_q;
  logic [SW-1:0] pend_w_q;
  logic [TW-1:0] n_q;

  logic                out_valid_q;
  slma_pkg::out_item_t out_q;

  logic                        a_more, b_more, pick_a;
  logic [KW-1:0]               sel_key;
  logic [slma_pkg::WeightW-1:0] sel_w;
  logic                        combine, open_new, out_stall;
  logic                        do_take, do_flush, emit_mid;
  logic                        a_wr, b_wr;

  assign a_more    = ia_q < cnt_a_q;
  assign b_more    = ib_q < cnt_b_q;
  assign pick_a    = a_more && (!b_more || (rd_a_q[EW-1 -: KW] <= rd_b_q[EW-1 -: KW]));
  assign sel_key   = pick_a ? rd_a_q[EW-1 -: KW] : rd_b_q[EW-1 -: KW];
  assign sel_w     = pick_a ? rd_a_q[slma_pkg::WeightW-1:0] : rd_b_q[slma_pkg::WeightW-1:0];
  assign combine   = have_q && (sel_key == pend_key_q);
  assign open_new  = !combine && (sel_key != skip_q);
  assign out_stall = out_valid_q && !out_ready_i;

  assign sts_o.a_more      = a_more;
  assign sts_o.b_more      = b_more;
  assign sts_o.take_stall  = open_new && have_q && out_stall;
  assign sts_o.flush_stall = out_stall;

  assign do_take  = cmd_i.take && !sts_o.take_stall;
  assign do_flush = cmd_i.flush && !out_stall;
  assign emit_mid = do_take && open_new && have_q;

  assign a_wr = cmd_i.load_a && (cnt_a_q < CW'(LIST_DEPTH));
  assign b_wr = cmd_i.load_b && (cnt_b_q < CW'(LIST_DEPTH));

  // list memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      mem_a[cnt_a_q[AW-1:0]] <= {in_data_i.key, in_data_i.weight};
    end
    if (b_wr) begin
      mem_b[cnt_b_q[AW-1:0]] <= {in_data_i.key, in_data_i.weight};
    end
    rd_a_q <= mem_a[ia_q[AW-1:0]];
    rd_b_q <= mem_b[ib_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      ia_q    <= '0;
      ib_q    <= '0;
      flag_q  <= 1'b0;
      have_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      if (a_wr) begin
        cnt_a_q <= cnt_a_q + CW'(1);
      end
      if (b_wr) begin
        cnt_b_q <= cnt_b_q + CW'(1);
      end
      if ((cmd_i.load_a && !a_wr) || (cmd_i.load_b && !b_wr)) begin
        flag_q <= 1'b1;
      end
      if (cmd_i.start) begin
        ia_q   <= '0;
        ib_q   <= '0;
        have_q <= 1'b0;
        n_q    <= '0;
      end
      if (do_take) begin
        if (pick_a) begin
          ia_q <= ia_q + CW'(1);
        end else begin
          ib_q <= ib_q + CW'(1);
        end
        if (open_new) begin
          have_q <= 1'b1;
          n_q    <= n_q + TW'(1);
        end
      end
      if (do_flush) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
        ia_q    <= '0;
        ib_q    <= '0;
        flag_q  <= 1'b0;
        have_q  <= 1'b0;
        n_q     <= '0;
      end
    end
  end

  // skip key and pending result: the result grows while equal keys arrive
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      skip_q <= in_data_i.skip_key;
    end
    if (do_take) begin
      if (combine) begin
        pend_w_q <= pend_w_q + {{(SW - slma_pkg::WeightW){1'b0}}, sel_w};
      end else if (open_new) begin
        pend_key_q <= sel_key;
        pend_w_q   <= {{(SW - slma_pkg::WeightW){1'b0}}, sel_w};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_mid || do_flush) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_mid) begin
      out_q.out_key    <= pend_key_q;
      out_q.out_weight <= pend_w_q;
      out_q.last       <= 1'b0;
      out_q.empty_res  <= 1'b0;
      out_q.total      <= '0;
      out_q.overflow   <= flag_q;
    end else if (do_flush) begin
      out_q.out_key    <= have_q ? pend_key_q : '0;
      out_q.out_weight <= have_q ? pend_w_q : '0;
      out_q.last       <= 1'b1;
      out_q.empty_res  <= !have_q;
      out_q.total      <= have_q ? n_q : '0;
      out_q.overflow   <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ia_q <= cnt_a_q) && (ib_q <= cnt_b_q))
    else $error("merge index beyond list count");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CW'(LIST_DEPTH)) && (cnt_b_q <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");

  a_n_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= TW'(2 * LIST_DEPTH))
    else $error("result count beyond both lists");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_flush |=> (out_valid_q && out_q.last))
    else $error("flush did not present a last result");

endmodule

// ===== src/sorted_list_merge_aggregate.sv =====
// Sorted list merge with duplicate combining: two ascending key/weight lists,
// merged on request into one result per distinct key.
// Loads are accepted back to back. A merge runs a start step, then a memory
//   read and a take for each stored entry, a final check and a flush, plus
//   any time the output side holds off a result; no new transaction is
//   accepted until the merge is done.
// Reset: asynchronous, active low; clears counts, the drop flag and control.
module sorted_list_merge_aggregate #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slma_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slma_pkg::out_item_t out_data_o
);

  // Command and status between the sequencer and the datapath
  slma_pkg::cmd_t cmd;
  slma_pkg::sts_t sts;

  // The controller accepts a transaction only in its idle state; loads are
  // passed on as write commands, a merge starts the walk over both lists.
  slma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (in_data_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the lists, picks the smaller head (A on ties), folds
  // equal keys into the pending result and drops the skip key. Results
  // leave through an output register, so new transactions are taken while
  // a finished result still waits downstream.
  slma_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for sorted_list_merge_aggregate: drives load and merge
// transactions, predicts every merged result and checks it field by field.
// Depends only on slma_pkg and the block's RTL.
module tb_top;

  localparam int unsigned Depth       = 32;
  localparam logic [1:0]  OpUnused    = 2'd3;    // opcode the block must ignore
  localparam int unsigned RandomItems = 240;
  localparam int unsigned TailCycles  = 160;     // longer than a full 64-entry merge
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned MaxPrints   = 40;

  // Output-side stall styles
  typedef enum int unsigned {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_style_e;

  // How load keys are drawn
  typedef enum int unsigned {
    KEY_NEAR,
    KEY_WIDE,
    KEY_EDGE
  } key_style_e;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  slma_pkg::in_item_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  slma_pkg::out_item_t out_data_o;

  // Shadow copy of the two lists and the drop flag
  logic [31:0] lst_a_key [Depth];
  logic [31:0] lst_a_wt  [Depth];
  logic [31:0] lst_b_key [Depth];
  logic [31:0] lst_b_wt  [Depth];
  int unsigned a_len     = 0;
  int unsigned b_len     = 0;
  logic        drop_pend = 1'b0;

  // Merged results still owed by the block, oldest first
  slma_pkg::out_item_t merged_q[$];

  int unsigned n_loads   = 0;
  int unsigned n_drops   = 0;
  int unsigned n_merges  = 0;
  int unsigned n_results = 0;
  int unsigned n_items   = 0;
  int unsigned n_errors  = 0;
  int unsigned cycles    = 0;

  // Sender and receiver pacing
  bit          tx_bursty  = 1'b0;
  int unsigned burst_left = 0;
  rx_style_e   rx_mode    = RX_OPEN;
  int unsigned rx_hold    = 0;

  sorted_list_merge_aggregate #(
    .LIST_DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               merged_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    n_errors++;
    if (n_errors <= MaxPrints)
      $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
  endtask

  // Update the shadow lists with one accepted transaction and queue any
  // merged results it owes. Mirrors the walk: A wins ties, an entry equal to
  // the last emitted key folds into it, a skip-key entry is dropped.
  task automatic track_lists(input slma_pkg::in_item_t it);
    slma_pkg::out_item_t acc[$];
    slma_pkg::out_item_t ent;
    int unsigned ia;
    int unsigned ib;
    int unsigned n;
    logic [31:0] k;
    logic [31:0] w;
    logic        pick_a;
    ia = 0;
    ib = 0;
    case (it.opcode)
      slma_pkg::OP_LOAD_A: begin
        n_loads++;
        if (a_len >= Depth) begin
          drop_pend = 1'b1;
          n_drops++;
        end else begin
          lst_a_key[a_len] = it.key;
          lst_a_wt[a_len]  = it.weight;
          a_len++;
        end
      end
      slma_pkg::OP_LOAD_B: begin
        n_loads++;
        if (b_len >= Depth) begin
          drop_pend = 1'b1;
          n_drops++;
        end else begin
          lst_b_key[b_len] = it.key;
          lst_b_wt[b_len]  = it.weight;
          b_len++;
        end
      end
      slma_pkg::OP_MERGE: begin
        n_merges++;
        while (ia < a_len || ib < b_len) begin
          if (ia < a_len && ib < b_len) pick_a = lst_a_key[ia] <= lst_b_key[ib];
          else pick_a = ia < a_len;
          if (pick_a) begin
            k = lst_a_key[ia];
            w = lst_a_wt[ia];
            ia++;
          end else begin
            k = lst_b_key[ib];
            w = lst_b_wt[ib];
            ib++;
          end
          n = acc.size();
          if (n > 0 && acc[n-1].out_key == k) begin
            // fold into the result just opened
            ent = acc[n-1];
            ent.out_weight = ent.out_weight + 40'(w);
            acc[n-1] = ent;
          end else if (k != it.skip_key) begin
            ent = '0;
            ent.out_key    = k;
            ent.out_weight = 40'(w);
            ent.overflow   = drop_pend;
            acc.push_back(ent);
          end
        end
        n = acc.size();
        if (n == 0) begin
          // nothing survived: one empty marker result
          ent = '0;
          ent.last      = 1'b1;
          ent.empty_res = 1'b1;
          ent.overflow  = drop_pend;
          acc.push_back(ent);
        end else begin
          ent = acc[n-1];
          ent.last  = 1'b1;
          ent.total = 7'(n);
          acc[n-1] = ent;
        end
        foreach (acc[i]) merged_q.push_back(acc[i]);
        a_len     = 0;
        b_len     = 0;
        drop_pend = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic slma_pkg::in_item_t mk_item(input logic [1:0] op,
                                                 input logic [31:0] key,
                                                 input logic [31:0] wt,
                                                 input logic [31:0] skip);
    slma_pkg::in_item_t it;
    it.opcode   = op;
    it.key      = key;
    it.weight   = wt;
    it.skip_key = skip;
    return it;
  endfunction

  function automatic logic [31:0] draw_key(input key_style_e style, input logic [31:0] base);
    case (style)
      KEY_NEAR: return base + 32'($urandom_range(0, 7));
      KEY_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] draw_weight();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned draw_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 6);
    if (r < 19) return $urandom_range(7, 16);
    return $urandom_range(30, 34);   // reaches and passes a full list
  endfunction

  // Present one transaction and hold it until accepted; then maybe open a gap.
  task automatic send_item(input slma_pkg::in_item_t it);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    track_lists(it);
    if (it.opcode != OpUnused) n_items++;
    if (tx_bursty) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 6);
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Drop valid and hold off until every owed result has been taken.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk_i);
  endtask

  // Fill both lists (in interleaved order) and merge them.
  task automatic load_and_merge(input int unsigned na, input int unsigned nb,
                                input key_style_e style, input bit sorted_keys,
                                input bit drain_first);
    logic [31:0] ka[$];
    logic [31:0] kb[$];
    logic [31:0] base;
    logic [31:0] skip;
    int unsigned ia;
    int unsigned ib;
    int unsigned idx;
    base = $urandom();
    repeat (na) ka.push_back(draw_key(style, base));
    repeat (nb) kb.push_back(draw_key(style, base));
    if (sorted_keys) begin
      ka.sort();
      kb.sort();
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 0)) begin
        send_item(mk_item(slma_pkg::OP_LOAD_A, ka[ia], draw_weight(), $urandom()));
        ia++;
      end else begin
        send_item(mk_item(slma_pkg::OP_LOAD_B, kb[ib], draw_weight(), $urandom()));
        ib++;
      end
    end
    // Mostly skip a key that is really present
    if (na + nb > 0 && $urandom_range(0, 3) != 0) begin
      idx  = $urandom_range(0, na + nb - 1);
      skip = (idx < na) ? ka[idx] : kb[idx - na];
    end else begin
      skip = $urandom();
    end
    if (drain_first) wait_for_drain();
    send_item(mk_item(slma_pkg::OP_MERGE, $urandom(), $urandom(), skip));
  endtask

  // Receiver: stall on its own pattern, chosen per phase
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_ready_i <= 1'b1;
        RX_LIGHT: begin
          if ($urandom_range(0, 9) == 0) begin
            rx_hold = $urandom_range(0, 2);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
        RX_HEAVY: begin
          if ($urandom_range(0, 9) < 4) begin
            rx_hold = $urandom_range(0, 5);
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
        default: out_ready_i <= ~out_ready_i;
      endcase
    end
  end

  // Compare each accepted result transaction against the oldest owed one
  always @(posedge clk_i) begin : check_results
    slma_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (merged_q.size() == 0) begin
        flag_mismatch("result with nothing pending, key", 64'(out_data_o.out_key), '0);
      end else begin
        want = merged_q.pop_front();
        if (out_data_o.out_key !== want.out_key)
          flag_mismatch("out_key", 64'(out_data_o.out_key), 64'(want.out_key));
        if (out_data_o.out_weight !== want.out_weight)
          flag_mismatch("out_weight", 64'(out_data_o.out_weight), 64'(want.out_weight));
        if (out_data_o.last !== want.last)
          flag_mismatch("last", 64'(out_data_o.last), 64'(want.last));
        if (out_data_o.empty_res !== want.empty_res)
          flag_mismatch("empty_res", 64'(out_data_o.empty_res), 64'(want.empty_res));
        if (out_data_o.total !== want.total)
          flag_mismatch("total", 64'(out_data_o.total), 64'(want.total));
        if (out_data_o.overflow !== want.overflow)
          flag_mismatch("overflow", 64'(out_data_o.overflow), 64'(want.overflow));
      end
    end
  end

  // Merge with both lists empty: expect the empty marker
  task automatic test_empty_merge();
    send_item(mk_item(slma_pkg::OP_MERGE, '0, '0, '0));
  endtask

  // Keys and weights at both ends of their range; equal keys fold across lists
  task automatic test_extreme_keys();
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));
    send_item(mk_item(slma_pkg::OP_LOAD_B, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(slma_pkg::OP_LOAD_B, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000));
    send_item(mk_item(slma_pkg::OP_MERGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A));
  endtask

  // Skip key on the first entry and its duplicate: neither may open a result
  task automatic test_skip_first();
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'd7, 32'd1, '0));
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'd7, 32'd2, '0));
    send_item(mk_item(slma_pkg::OP_LOAD_B, 32'd9, 32'd3, '0));
    send_item(mk_item(slma_pkg::OP_MERGE, '0, '0, 32'd7));
  endtask

  // Unsorted list A, plus an unused opcode that must change nothing
  task automatic test_unsorted_unused_op();
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'd5, 32'd10, '0));
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'd2, 32'd20, '0));
    send_item(mk_item(slma_pkg::OP_LOAD_B, 32'd5, 32'd30, '0));
    send_item(mk_item(OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_item(slma_pkg::OP_MERGE, '0, '0, 32'd0));
  endtask

  // Every entry skipped: expect the empty marker
  task automatic test_all_skipped();
    send_item(mk_item(slma_pkg::OP_LOAD_A, 32'd4, 32'd1, '0));
    send_item(mk_item(slma_pkg::OP_LOAD_B, 32'd4, 32'd1, '0));
    send_item(mk_item(slma_pkg::OP_MERGE, '0, '0, 32'd4));
  endtask

  // Overfill both lists with distinct keys: 64 results, overflow set on all
  task automatic test_full_lists();
    logic [31:0] base;
    rx_mode   = RX_HEAVY;
    tx_bursty = 1'b1;
    base      = 32'($urandom_range(1, 1000));
    wait_for_drain();
    for (int i = 0; i < Depth + 2; i++) begin
      send_item(mk_item(slma_pkg::OP_LOAD_A, base + 32'(2 * i), draw_weight(), $urandom()));
      send_item(mk_item(slma_pkg::OP_LOAD_B, base + 32'(2 * i + 1), draw_weight(),
                        $urandom()));
    end
    send_item(mk_item(slma_pkg::OP_MERGE, $urandom(), $urandom(), base - 32'd1));
  endtask

  // Random phases: mostly well-formed sorted loads then a merge, some
  // unsorted lists, some raw noise; pacing changes per phase.
  task automatic test_random_merges();
    int unsigned start;
    int unsigned phase;
    int unsigned shape;
    start = n_items;
    phase = 0;
    while (n_items - start < RandomItems) begin
      rx_mode   = rx_style_e'($urandom_range(0, 3));
      tx_bursty = $urandom_range(0, 3) != 0;
      shape     = $urandom_range(0, 9);
      if (shape == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(mk_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom()));
      end else begin
        load_and_merge(draw_len(), draw_len(), key_style_e'($urandom_range(0, 2)),
                       shape != 1, (phase % 8) == 3);
      end
      phase++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_merge();
    test_extreme_keys();
    test_skip_first();
    test_unsorted_unused_op();
    test_all_skipped();
    test_full_lists();
    test_random_merges();

    // Stop sending, take every owed result, then watch for strays
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    rx_mode = RX_OPEN;
    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d loads (%0d hit a full list) and %0d merges; checked %0d results.",
             n_loads, n_drops, n_merges, n_results);
    $display("Mismatches: %0d over %0d cycles.", n_errors, cycles);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
